// ----- hdl/mcid_pkg.sv -----
// ----------------------------------------------------------------------------
// mcid_pkg: shared types and constants of the multi-channel input debouncer
// Channel counts, time width, config register indexes and item payloads.
// ----------------------------------------------------------------------------
package mcid_pkg;

  // Channel layout: inputs in the low lanes, buttons above them
  localparam int NumInputs    = 8;
  localparam int NumButtons   = 3;
  localparam int NumChannels  = NumInputs + NumButtons;
  localparam int TimeBits     = 32;
  localparam int DebounceBits = 16;

  // Config port
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = DebounceBits;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_INPUT_DEBOUNCE     = 2'd0,
    CFG_BUTTON_DEBOUNCE    = 2'd1,
    CFG_INPUTS_ACTIVE_HIGH = 2'd2,
    CFG_BUTTONS_ACTIVE_LOW = 2'd3
  } cfg_idx_e;

  // Reset values of the config registers
  localparam logic [DebounceBits-1:0] InputDebounceRst  = DebounceBits'(20);
  localparam logic [DebounceBits-1:0] ButtonDebounceRst = DebounceBits'(50);
  localparam logic                    InputsActiveHighRst = 1'b1;
  localparam logic                    ButtonsActiveLowRst = 1'b1;

  // Input item
  typedef struct packed {
    logic [TimeBits-1:0]   now_ms;
    logic [NumInputs-1:0]  input_levels;
    logic [NumButtons-1:0] button_levels;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [NumInputs-1:0]  input_mask;
    logic [NumButtons-1:0] buttons_down;
    logic [NumButtons-1:0] buttons_pressed;
  } out_item_t;

  // What one lane reports to the merge stage
  typedef struct packed {
    logic stable;  // debounced level after this item
    logic rise;    // stable level went inactive -> active on this item
  } lane_res_t;

endpackage

// ----- hdl/mcid_if.sv -----
// ----------------------------------------------------------------------------
// mcid_if: stream interfaces of the debouncer
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface mcid_in_if;
  logic              valid;
  logic              ready;
  mcid_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mcid_out_if;
  logic               valid;
  logic               ready;
  mcid_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/mcid_lane.sv -----
// ----------------------------------------------------------------------------
// mcid_lane: one debounce channel
// Holds raw level, stable level and last change time of a single channel.
// ----------------------------------------------------------------------------
module mcid_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic                                primed_i,
  input  logic                                act_i,
  input  logic [mcid_pkg::TimeBits-1:0]       now_i,
  input  logic [mcid_pkg::DebounceBits-1:0]   limit_i,
  output mcid_pkg::lane_res_t                 res_o
);

  logic                          raw_q, raw_d;
  logic                          stable_q, stable_d;
  logic [mcid_pkg::TimeBits-1:0] ct_q, ct_d;

  logic                          raw_cur;
  logic                          stable_cur;
  logic [mcid_pkg::TimeBits-1:0] ct_cur;
  logic [mcid_pkg::TimeBits-1:0] elapsed;

  // First item after reset primes the channel from the current sample
  assign raw_cur    = primed_i ? raw_q    : act_i;
  assign stable_cur = primed_i ? stable_q : act_i;
  assign ct_cur     = primed_i ? ct_q     : now_i;

  // Raw change restamps; stable follows once the level held long enough
  always_comb begin
    raw_d    = act_i;
    ct_d     = (act_i != raw_cur) ? now_i : ct_cur;
    elapsed  = now_i - ct_d;
    stable_d = stable_cur;
    if ((raw_d != stable_cur) && (elapsed >= mcid_pkg::TimeBits'(limit_i))) begin
      stable_d = raw_d;
    end
  end

  assign res_o.stable = stable_d;
  assign res_o.rise   = stable_d & ~stable_cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q    <= 1'b0;
      stable_q <= 1'b0;
      ct_q     <= '0;
    end else if (accept_i) begin
      raw_q    <= raw_d;
      stable_q <= stable_d;
      ct_q     <= ct_d;
    end
  end

endmodule

// ----- hdl/mcid_merge.sv -----
// ----------------------------------------------------------------------------
// mcid_merge: result assembly and output register
// Gathers the lane results into one item and holds it until taken.
// ----------------------------------------------------------------------------
module mcid_merge (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          accept_i,
  input  mcid_pkg::lane_res_t [mcid_pkg::NumChannels-1:0] lane_res_i,
  output logic                                          in_ready_o,
  mcid_out_if.source                                    out_o
);

  logic                valid_q, valid_d;
  mcid_pkg::out_item_t data_q, data_d;

  // Pack lane results: inputs first, buttons above
  always_comb begin
    for (int i = 0; i < mcid_pkg::NumInputs; i++) begin
      data_d.input_mask[i] = lane_res_i[i].stable;
    end
    for (int j = 0; j < mcid_pkg::NumButtons; j++) begin
      data_d.buttons_down[j]    = lane_res_i[mcid_pkg::NumInputs + j].stable;
      data_d.buttons_pressed[j] = lane_res_i[mcid_pkg::NumInputs + j].rise;
    end
  end

  // Output register frees up in the same cycle it is taken
  assign in_ready_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      data_q <= data_d;
    end
  end

  assign out_o.valid = valid_q;
  assign out_o.data  = data_q;

endmodule

// ----- hdl/multi_channel_input_debouncer_unit.sv -----
// ----------------------------------------------------------------------------
// multi_channel_input_debouncer_unit: time-based debouncer, 8 inputs, 3 buttons
// Config registers, polarity mapping, per-channel lanes and result merge.
// ----------------------------------------------------------------------------
// Takes one item per clock: each item is a millisecond timestamp plus the raw
// levels of 8 input pins and 3 button pins, and yields one result item with
// the debounced input mask, the debounced button levels and the buttons that
// just became active. Every channel is an independent lane doing one 32-bit
// wrapping subtract and compare, so an item is accepted every cycle and its
// result is written to the output register on acceptance; the only stall
// comes from the result side holding ready low while a result is waiting.
// The first item after reset primes all channels from its own levels and
// timestamp. The user writes debounce times and polarities through the
// config port only while the block is idle; the block does not enforce it.
// A polarity change is debounced like any other level change.
module multi_channel_input_debouncer_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mcid_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [mcid_pkg::CfgDataBits-1:0]    cfg_data_i,
  mcid_in_if.sink                             in_i,
  mcid_out_if.source                          out_o
);

  logic [mcid_pkg::DebounceBits-1:0] in_deb_q;
  logic [mcid_pkg::DebounceBits-1:0] btn_deb_q;
  logic                              in_high_q;
  logic                              btn_low_q;
  logic                              primed_q;

  logic                                    accept;
  logic                                    in_ready;
  logic [mcid_pkg::NumInputs-1:0]          in_act;
  logic [mcid_pkg::NumButtons-1:0]         btn_act;
  logic [mcid_pkg::NumChannels-1:0]        act;
  mcid_pkg::lane_res_t [mcid_pkg::NumChannels-1:0] lane_res;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_deb_q  <= mcid_pkg::InputDebounceRst;
      btn_deb_q <= mcid_pkg::ButtonDebounceRst;
      in_high_q <= mcid_pkg::InputsActiveHighRst;
      btn_low_q <= mcid_pkg::ButtonsActiveLowRst;
    end else if (cfg_we_i) begin
      case (mcid_pkg::cfg_idx_e'(cfg_idx_i))
        mcid_pkg::CFG_INPUT_DEBOUNCE:     in_deb_q  <= cfg_data_i;
        mcid_pkg::CFG_BUTTON_DEBOUNCE:    btn_deb_q <= cfg_data_i;
        mcid_pkg::CFG_INPUTS_ACTIVE_HIGH: in_high_q <= cfg_data_i[0];
        mcid_pkg::CFG_BUTTONS_ACTIVE_LOW: btn_low_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  // Primed after the first accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
    end else if (accept) begin
      primed_q <= 1'b1;
    end
  end

  // Pin levels to active levels
  assign in_act  = in_high_q ? in_i.data.input_levels : ~in_i.data.input_levels;
  assign btn_act = btn_low_q ? ~in_i.data.button_levels : in_i.data.button_levels;
  assign act     = {btn_act, in_act};

  // One lane per channel
  for (genvar c = 0; c < mcid_pkg::NumChannels; c++) begin : g_lane
    mcid_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .accept_i (accept),
      .primed_i (primed_q),
      .act_i    (act[c]),
      .now_i    (in_i.data.now_ms),
      .limit_i  ((c < mcid_pkg::NumInputs) ? in_deb_q : btn_deb_q),
      .res_o    (lane_res[c])
    );
  end

  mcid_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .lane_res_i (lane_res),
    .in_ready_o (in_ready),
    .out_o      (out_o)
  );

endmodule
